/* design/cbf_pkg.sv */
// cbf_pkg: shared types and constants of the conv batchnorm folding unit
// no dependencies; used by conv_batchnorm_fold_unit and its bench

package cbf_pkg;

  // item commands and result kinds
  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_WEIGHT  = 1'b1;
  localparam logic KIND_BIAS   = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  // register defaults and data limits
  localparam logic [15:0] EPS_RESET = 16'd168;
  localparam logic [31:0] SCALE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SCALE_MIN = 32'h8000_0000;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DIV,
    ST_SCALE,
    ST_MUL_GO,
    ST_MUL,
    ST_ROUND,
    ST_FIN
  } cbf_state_t;

endpackage

/* design/cbf_sqrt.sv */
// cbf_sqrt: serial integer square root of (arg << FRAC_BITS), two radicand bits per cycle
// depends on nothing beyond its ports

module cbf_sqrt #(
  parameter int FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [31:0]                       arg,
  output logic [((32+FRAC_BITS+1)/2)-1:0]   root,
  output logic                              done
);

  localparam int RAD_W  = ((32 + FRAC_BITS + 1) / 2) * 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // one root digit per cycle: bring down two bits, try {root, 01}
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    ge       = (rem_sh >= trial);
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = RAD_W'({arg, {FRAC_BITS{1'b0}}});
      root_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

/* design/cbf_div.sv */
// cbf_div: restoring divider, (num_mag << FRAC_BITS) / den, one quotient bit per cycle
// depends on nothing beyond its ports

module cbf_div #(
  parameter int FRAC_BITS = 24,
  parameter int DEN_W     = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      num_mag,
  input  logic [DEN_W-1:0] den,
  output logic [32:0]      quo,
  output logic             ovf,
  output logic             done
);

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [32:0]      quo_r, quo_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // one quotient bit per cycle; bits beyond 33 only set the overflow mark
  // a zero divisor gives all ones, which the caller treats as saturation
  always_comb begin
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = {num_mag, {FRAC_BITS{1'b0}}};
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt  = {num_r[NUM_W-2:0], 1'b0};
      rem_nxt  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_nxt  = {quo_r[31:0], ge};
      ovf_nxt  = ovf_r | quo_r[32];
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign quo  = quo_r;
  assign ovf  = ovf_r;
  assign done = done_r;

endmodule

/* design/cbf_mul.sv */
// cbf_mul: serial shift-add multiplier of two magnitudes, one multiplier bit per cycle
// depends on nothing beyond its ports

module cbf_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] a_mag,
  input  logic [31:0] b_mag,
  output logic [64:0] prod,
  output logic        done
);

  localparam int STEPS = 32;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [32:0]      a_r, a_nxt;
  logic [32:0]      hi_r, hi_nxt;
  logic [31:0]      lo_r, lo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [33:0]      sum;

  // add the multiplicand on a set low bit, then shift the pair right
  always_comb begin
    sum      = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : 34'd0);
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a_mag;
      hi_nxt   = '0;
      lo_nxt   = b_mag;
      cnt_nxt  = CNT_W'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum[33:1];
      lo_nxt  = {sum[0], lo_r[31:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // product shift register
  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign prod = {hi_r, lo_r};
  assign done = done_r;

endmodule

/* design/conv_batchnorm_fold_unit.sv */
// conv_batchnorm_fold_unit: top level; one request at a time, header through sqrt, divide, multiply
// weight request: multiply start, 32-step serial multiply, round, then result load
// header request: (33 + FRAC_BITS) / 2 root steps, (32 + FRAC_BITS) divide steps and a scale clamp,
//   then the weight path; the next request waits for the result load, so a stalled result holds it off
// reset: synchronous active low; epsilon returns to 168, kept scale and its flag to zero
// uses cbf_pkg, cbf_sqrt, cbf_div, cbf_mul

module conv_batchnorm_fold_unit #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic signed [31:0] in_gamma,
  input  logic signed [31:0] in_beta,
  input  logic signed [31:0] in_running_mean,
  input  logic [30:0]        in_variance,
  input  logic signed [31:0] in_conv_bias,
  input  logic signed [31:0] in_weight,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_result_kind,
  output logic signed [31:0] out_folded_value,
  output logic               out_saturated
);

  localparam int ROOT_W = (32 + FRAC_BITS + 1) / 2;
  localparam int RND_W  = 66 - FRAC_BITS;
  localparam int VAL_W  = RND_W + 2;
  localparam logic [65:0] HALF = 66'(1) << (FRAC_BITS - 1);
  localparam logic signed [VAL_W-1:0] VAL_MAX = {{(VAL_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {{(VAL_W-31){1'b1}}, 31'd0};

  cbf_pkg::cbf_state_t state_r, state_nxt;

  logic [15:0]        eps_r;
  logic signed [31:0] scale_r, scale_nxt;
  logic               scale_sat_r, scale_sat_nxt;
  logic               cmd_r;
  logic signed [31:0] gamma_r;
  logic signed [31:0] beta_r;
  logic signed [32:0] opnd_r;
  logic               neg_r;
  logic [RND_W-1:0]   rnd_r;
  logic               out_valid_r;
  logic               out_kind_r;
  logic signed [31:0] out_value_r;
  logic               out_sat_r;

  logic               accept;
  logic               out_free;
  logic               sqrt_start, div_start, mul_start, out_load;
  logic [31:0]        sqrt_arg;
  logic [ROOT_W-1:0]  root;
  logic               sqrt_done;
  logic [31:0]        gamma_mag;
  logic [32:0]        quo;
  logic               quo_ovf;
  logic               div_done;
  logic [32:0]        a_mag;
  logic [31:0]        b_mag;
  logic [64:0]        prod;
  logic               mul_done;
  logic [65:0]        rnd_sum;
  logic signed [VAL_W-1:0] addend;
  logic signed [VAL_W-1:0] rnd_ext;
  logic signed [VAL_W-1:0] val;
  logic               val_sat;
  logic signed [31:0] val_clip;
  logic               big_pos, big_neg;

  assign in_stall = (state_r != cbf_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_command == cbf_pkg::CMD_WEIGHT) ? cbf_pkg::ST_MUL_GO : cbf_pkg::ST_SQRT;
        end
      end
      cbf_pkg::ST_SQRT:   if (sqrt_done) state_nxt = cbf_pkg::ST_DIV;
      cbf_pkg::ST_DIV:    if (div_done) state_nxt = cbf_pkg::ST_SCALE;
      cbf_pkg::ST_SCALE:  state_nxt = cbf_pkg::ST_MUL_GO;
      cbf_pkg::ST_MUL_GO: state_nxt = cbf_pkg::ST_MUL;
      cbf_pkg::ST_MUL:    if (mul_done) state_nxt = cbf_pkg::ST_ROUND;
      cbf_pkg::ST_ROUND:  state_nxt = cbf_pkg::ST_FIN;
      cbf_pkg::ST_FIN:    if (out_free) state_nxt = cbf_pkg::ST_IDLE;
      default:            state_nxt = cbf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sqrt_start = accept && (in_command == cbf_pkg::CMD_HEADER);
    div_start  = (state_r == cbf_pkg::ST_SQRT) && sqrt_done;
    mul_start  = (state_r == cbf_pkg::ST_MUL_GO);
    out_load   = (state_r == cbf_pkg::ST_FIN) && out_free;
  end

  // serial units
  assign sqrt_arg  = 32'(in_variance) + 32'(eps_r);
  assign gamma_mag = gamma_r[31] ? (32'd0 - gamma_r) : gamma_r;
  assign a_mag     = opnd_r[32] ? (33'd0 - opnd_r) : opnd_r;
  assign b_mag     = scale_r[31] ? (32'd0 - scale_r) : scale_r;

  cbf_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .arg   (sqrt_arg),
    .root  (root),
    .done  (sqrt_done)
  );

  cbf_div #(.FRAC_BITS(FRAC_BITS), .DEN_W(ROOT_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (gamma_mag),
    .den     (root),
    .quo     (quo),
    .ovf     (quo_ovf),
    .done    (div_done)
  );

  cbf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_mag (a_mag),
    .b_mag (b_mag),
    .prod  (prod),
    .done  (mul_done)
  );

  // clamp the quotient into the signed scale; a zero root lands here as overflow
  always_comb begin
    big_pos       = quo_ovf || quo[32] || quo[31];
    big_neg       = quo_ovf || quo[32] || (quo[31] && (|quo[30:0]));
    scale_nxt     = scale_r;
    scale_sat_nxt = scale_sat_r;
    if (state_r == cbf_pkg::ST_SCALE) begin
      if (gamma_r[31]) begin
        scale_nxt     = big_neg ? cbf_pkg::SCALE_MIN : (32'd0 - quo[31:0]);
        scale_sat_nxt = big_neg;
      end else begin
        scale_nxt     = big_pos ? cbf_pkg::SCALE_MAX : quo[31:0];
        scale_sat_nxt = big_pos;
      end
    end
  end

  // rounding, sign, bias add and saturation
  always_comb begin
    rnd_sum  = {1'b0, prod} + HALF;
    addend   = (cmd_r == cbf_pkg::CMD_HEADER) ? VAL_W'(beta_r) : '0;
    rnd_ext  = VAL_W'(rnd_r);
    val      = neg_r ? (addend - rnd_ext) : (addend + rnd_ext);
    val_sat  = (val > VAL_MAX) || (val < VAL_MIN);
    if (val > VAL_MAX) begin
      val_clip = cbf_pkg::SCALE_MAX;
    end else if (val < VAL_MIN) begin
      val_clip = cbf_pkg::SCALE_MIN;
    end else begin
      val_clip = val[31:0];
    end
  end

  // control and kept state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbf_pkg::ST_IDLE;
      eps_r       <= cbf_pkg::EPS_RESET;
      scale_r     <= '0;
      scale_sat_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scale_r     <= scale_nxt;
      scale_sat_r <= scale_sat_nxt;
      if (cfg_wr_en) begin
        eps_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      gamma_r <= in_gamma;
      beta_r  <= in_beta;
      opnd_r  <= (in_command == cbf_pkg::CMD_WEIGHT) ? 33'(in_weight)
                                                     : (33'(in_conv_bias) - 33'(in_running_mean));
    end
    if (mul_start) begin
      neg_r <= opnd_r[32] ^ scale_r[31];
    end
    if (state_r == cbf_pkg::ST_ROUND) begin
      rnd_r <= rnd_sum[65:FRAC_BITS];
    end
    if (out_load) begin
      out_kind_r  <= (cmd_r == cbf_pkg::CMD_WEIGHT) ? cbf_pkg::KIND_WEIGHT : cbf_pkg::KIND_BIAS;
      out_value_r <= val_clip;
      out_sat_r   <= val_sat || scale_sat_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_folded_value = out_value_r;
  assign out_saturated    = out_sat_r;

  // a flagged scale always sits at one of the two limits
  a_scale_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    scale_sat_r |-> (scale_r == cbf_pkg::SCALE_MAX || scale_r == cbf_pkg::SCALE_MIN))
    else $error("flagged scale is not at a limit");

  // a weight request skips the root and divide
  a_weight_path: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == cbf_pkg::CMD_WEIGHT) |=> (state_r == cbf_pkg::ST_MUL_GO))
    else $error("weight request did not go straight to the multiply");

  // the serial units never finish in the same cycle
  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({sqrt_done, div_done, mul_done}))
    else $error("more than one serial unit finished at once");

  // loading the result frees the block for the next request
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == cbf_pkg::ST_IDLE))
    else $error("result load did not return to idle");

endmodule

/* verif/tb_conv_batchnorm_fold_unit.sv */
// tb_conv_batchnorm_fold_unit: self-checking bench for the batchnorm folding unit
// directed table of header and weight requests, then random channel sequences over several
// epsilon settings; depends on cbf_pkg and conv_batchnorm_fold_unit

module tb_conv_batchnorm_fold_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 24;
  // slowest legal quiet stretch is a header plus a long gap on each side
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_CAP = 100;
  localparam longint FOLD_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint FOLD_MIN = -64'sh0000_0000_8000_0000;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] gamma;
    logic signed [31:0] beta;
    logic signed [31:0] running_mean;
    logic [30:0]        variance;
    logic signed [31:0] conv_bias;
    logic signed [31:0] weight;
  } fold_req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        sat;
  } fold_t;

  typedef struct packed {
    fold_req_t   req;
    logic        typed;
    fold_t       want;
    logic        set_eps;
    logic [15:0] eps;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [15:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic               in_command;
  logic signed [31:0] in_gamma;
  logic signed [31:0] in_beta;
  logic signed [31:0] in_running_mean;
  logic [30:0]        in_variance;
  logic signed [31:0] in_conv_bias;
  logic signed [31:0] in_weight;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_result_kind;
  logic signed [31:0] out_folded_value;
  logic               out_saturated;

  // folding model state
  logic [15:0] eps_q = cbf_pkg::EPS_RESET;
  longint      scale_q = 0;
  logic        scale_clip = 1'b0;

  fold_t     pending_folds[$];
  plan_row_t plan[$];
  logic      steady = 1'b1;
  int        mismatches = 0;
  int        reports = 0;
  int        headers_sent = 0;
  int        weights_sent = 0;
  int        results_seen = 0;
  int        saturated_seen = 0;
  int        eps_settings = 1;
  int        stall_left = 0;
  int        quiet_cycles = 0;

  conv_batchnorm_fold_unit #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_gamma         (in_gamma),
    .in_beta          (in_beta),
    .in_running_mean  (in_running_mean),
    .in_variance      (in_variance),
    .in_conv_bias     (in_conv_bias),
    .in_weight        (in_weight),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_folded_value (out_folded_value),
    .out_saturated    (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact integer square root, bit by bit
  function automatic u64_t int_sqrt(input u64_t x);
    u64_t res;
    u64_t probe;
    res = 0;
    probe = u64_t'(1) << 62;
    while (probe > x) probe >>= 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic u64_t mag_of(input longint a);
    return (a < 0) ? u64_t'(-a) : u64_t'(a);
  endfunction

  // exact product, shifted down with round half away from zero
  function automatic longint round_mul(input longint a, input longint b);
    u64_t p;
    p = (mag_of(a) * mag_of(b) + (u64_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // expected result of one request; a header also replaces the kept scale
  function automatic fold_t fold_predict(input fold_req_t r);
    fold_t  f;
    u64_t   root;
    u64_t   quot;
    longint gamma;
    longint acc;
    logic   clipped;
    clipped = 1'b0;
    if (r.cmd == cbf_pkg::CMD_HEADER) begin
      gamma = longint'($signed(r.gamma));
      root = int_sqrt((u64_t'(r.variance) + u64_t'(eps_q)) << FRAC_BITS);
      if (root == 0) begin
        // zero divisor: scale pinned to the end of gamma's sign
        scale_q = (gamma < 0) ? FOLD_MIN : FOLD_MAX;
        scale_clip = 1'b1;
      end else begin
        quot = (mag_of(gamma) << FRAC_BITS) / root;
        scale_clip = 1'b0;
        if (gamma < 0) begin
          if (quot > u64_t'(64'h8000_0000)) begin
            quot = 64'h8000_0000;
            scale_clip = 1'b1;
          end
          scale_q = -longint'(quot);
        end else begin
          if (quot > u64_t'(64'h7FFF_FFFF)) begin
            quot = 64'h7FFF_FFFF;
            scale_clip = 1'b1;
          end
          scale_q = longint'(quot);
        end
      end
      acc = round_mul(longint'($signed(r.conv_bias)) - longint'($signed(r.running_mean)),
                      scale_q) + longint'($signed(r.beta));
      f.kind = cbf_pkg::KIND_BIAS;
    end else begin
      acc = round_mul(longint'($signed(r.weight)), scale_q);
      f.kind = cbf_pkg::KIND_WEIGHT;
    end
    if (acc > FOLD_MAX) begin
      acc = FOLD_MAX;
      clipped = 1'b1;
    end else if (acc < FOLD_MIN) begin
      acc = FOLD_MIN;
      clipped = 1'b1;
    end
    f.value = acc[31:0];
    f.sat = clipped | scale_clip;
    return f;
  endfunction

  // random q8.24 value: extremes, small magnitudes or any bit pattern
  function automatic logic [31:0] rand_q();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 32'h7FFF_FFFF;
    if (pick == 1) return 32'h8000_0000;
    if (pick < 6) return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
    return $urandom;
  endfunction

  function automatic logic [30:0] rand_var();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 31'h0;
    if (pick == 1) return 31'h7FFF_FFFF;
    if (pick < 5) return 31'($urandom_range(0, 32'h0100_0000));
    return 31'($urandom);
  endfunction

  // header request; the weight field is noise
  function automatic fold_req_t hdr(input logic [31:0] g, input logic [31:0] b,
                                    input logic [31:0] m, input logic [30:0] v,
                                    input logic [31:0] c);
    return fold_req_t'{cbf_pkg::CMD_HEADER, g, b, m, v, c, $urandom};
  endfunction

  // weight request; the header fields are noise
  function automatic fold_req_t wgt(input logic [31:0] w);
    return fold_req_t'{cbf_pkg::CMD_WEIGHT, $urandom, $urandom, $urandom, 31'($urandom),
                       $urandom, w};
  endfunction

  function automatic void add_row(input fold_req_t r, input logic typed = 1'b0,
                                  input fold_t want = '0, input logic set_eps = 1'b0,
                                  input logic [15:0] eps = '0);
    plan.push_back(plan_row_t'{r, typed, want, set_eps, eps});
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pause_cycles();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one request, hold it until taken, then log its expectation
  task automatic send_request(input fold_req_t r, input logic typed, input fold_t want);
    int gap;
    fold_t f;
    gap = pause_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= r.cmd;
    in_gamma        <= r.gamma;
    in_beta         <= r.beta;
    in_running_mean <= r.running_mean;
    in_variance     <= r.variance;
    in_conv_bias    <= r.conv_bias;
    in_weight       <= r.weight;
    do @(posedge clk); while (in_stall);
    f = fold_predict(r);
    pending_folds.push_back(typed ? want : f);
    if (r.cmd == cbf_pkg::CMD_HEADER) headers_sent++;
    else weights_sent++;
  endtask

  // stop requesting and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_folds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_epsilon(input logic [15:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    eps_q = v;
    eps_settings++;
  endtask

  // result stall generator
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pause_cycles();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // result checker
  always @(posedge clk) begin
    fold_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_saturated) saturated_seen++;
      if (pending_folds.size() == 0) begin
        mismatches++;
        if (reports++ < REPORT_CAP)
          $error("result with no request waiting: kind %0b value %h", out_result_kind,
                 out_folded_value);
      end else begin
        want = pending_folds.pop_front();
        if (out_result_kind !== want.kind) begin
          mismatches++;
          if (reports++ < REPORT_CAP)
            $error("result_kind: expected %0b, got %0b", want.kind, out_result_kind);
        end
        if (out_folded_value !== want.value) begin
          mismatches++;
          if (reports++ < REPORT_CAP)
            $error("folded_value: expected %h, got %h", want.value, out_folded_value);
        end
        if (out_saturated !== want.sat) begin
          mismatches++;
          if (reports++ < REPORT_CAP)
            $error("saturated: expected %0b, got %0b", want.sat, out_saturated);
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_folds.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [15:0] eps_plan[5];
    int          base;
    logic        paused;
    int          pick;

    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_command      <= cbf_pkg::CMD_HEADER;
    in_gamma        <= '0;
    in_beta         <= '0;
    in_running_mean <= '0;
    in_variance     <= '0;
    in_conv_bias    <= '0;
    in_weight       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // weights before any header see the reset scale of zero
    add_row(wgt(32'h7FFF_FFFF), 1'b1, fold_t'{cbf_pkg::KIND_WEIGHT, 32'h0, 1'b0});
    add_row(wgt(32'h8000_0000), 1'b1, fold_t'{cbf_pkg::KIND_WEIGHT, 32'h0, 1'b0});
    // zero gamma: folded bias is beta itself
    add_row(hdr(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
            fold_t'{cbf_pkg::KIND_BIAS, 32'h7FFF_FFFF, 1'b0});
    // unit scale with the default epsilon, weight extremes
    add_row(hdr(32'h0100_0000, 32'hFF80_0000, 32'h0200_0000, 31'h00FF_FF58, 32'h0300_0000));
    add_row(wgt(32'h7FFF_FFFF));
    add_row(wgt(32'h8000_0000));
    add_row(wgt(32'h0));
    add_row(wgt(32'h1));
    add_row(wgt(32'hFFFF_FFFF));
    // half scale: rounding ties go away from zero
    add_row(hdr(32'h0080_0000, 32'h0, 32'h0, 31'h00FF_FF58, 32'h0));
    add_row(wgt(32'h1));
    add_row(wgt(32'hFFFF_FFFF));
    add_row(wgt(32'h3));
    // scale, bias and weight overflow, all toward the positive limit
    add_row(hdr(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0, 32'h7FFF_FFFF));
    add_row(wgt(32'h7FFF_FFFF));
    add_row(hdr(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000));
    add_row(wgt(32'h8000_0000));
    // zero divisor with epsilon cleared, negative and zero gamma
    add_row(hdr(32'hFFFF_FFFB, 32'h1234_5678, 32'h7B, 31'h0, 32'h7B), 1'b1,
            fold_t'{cbf_pkg::KIND_BIAS, 32'h1234_5678, 1'b1}, 1'b1, 16'h0000);
    add_row(wgt(32'h0), 1'b1, fold_t'{cbf_pkg::KIND_WEIGHT, 32'h0, 1'b1});
    add_row(hdr(32'h0, 32'h8000_0000, 32'h55, 31'h0, 32'h55), 1'b1,
            fold_t'{cbf_pkg::KIND_BIAS, 32'h8000_0000, 1'b1});
    add_row(wgt(32'h0100_0000));
    add_row(wgt(32'hFFFF_FFFF));
    // largest epsilon
    add_row(hdr(32'hFF00_0000, 32'h1, $urandom, 31'h00FF_0001, $urandom), 1'b0, '0, 1'b1,
            16'hFFFF);
    add_row(wgt($urandom));
    add_row(hdr($urandom, $urandom, $urandom, 31'h7FFF_FFFF, $urandom));

    // directed walk, no idling
    foreach (plan[i]) begin
      if (plan[i].set_eps) begin
        drain_results();
        write_epsilon(plan[i].eps);
      end
      send_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    // random channels: header then a run of weights, with some stray requests
    eps_plan = '{16'($urandom), 16'h0000, 16'hFFFF, cbf_pkg::EPS_RESET,
                 16'($urandom_range(0, 255))};
    foreach (eps_plan[p]) begin
      drain_results();
      write_epsilon(eps_plan[p]);
      base = headers_sent + weights_sent;
      paused = 1'b0;
      while (headers_sent + weights_sent - base < 155) begin
        steady = ($urandom_range(0, 7) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          send_request(hdr(rand_q(), rand_q(), rand_q(), rand_var(), rand_q()), 1'b0, '0);
          repeat ($urandom_range(1, 10)) send_request(wgt(rand_q()), 1'b0, '0);
        end else if (pick == 8) begin
          repeat ($urandom_range(1, 4)) send_request(wgt(rand_q()), 1'b0, '0);
        end else begin
          repeat ($urandom_range(2, 3))
            send_request(hdr(rand_q(), rand_q(), rand_q(), rand_var(), rand_q()), 1'b0, '0);
        end
        // hold the sender until the unit has emptied out
        if (!paused && headers_sent + weights_sent - base >= 80) begin
          paused = 1'b1;
          drain_results();
        end
      end
    end

    steady = 1'b0;
    drain_results();
    repeat (150) @(posedge clk);

    $display("ran %0d header and %0d weight requests over %0d epsilon settings",
             headers_sent, weights_sent, eps_settings);
    $display("checked %0d results, %0d of them flagged saturated, %0d field mismatches",
             results_seen, saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
design/cbf_pkg.sv
design/cbf_sqrt.sv
design/cbf_div.sv
design/cbf_mul.sv
design/conv_batchnorm_fold_unit.sv
verif/tb_conv_batchnorm_fold_unit.sv
